// File: design/wsat_pkg.sv
// Shared types, command codes and constants for the weekly schedule alarm table.
// No dependencies; the controller, datapath and top level refer to this package by scoped name.
`timescale 1ns / 1ps

package wsat_pkg;

  // default table depth
  localparam int DEF_NUM_ENTRIES = 8;

  // field widths
  localparam int CMD_W     = 3;
  localparam int ROW_W     = 3;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int WDAY_W    = 3;
  localparam int MASK_W    = 7;
  localparam int COUNT_W   = 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET_TIME     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_PORTIONS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_WEEKDAY  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK         = 3'd4;

  // weekdays run Sunday (0) to Saturday (6)
  localparam logic [WDAY_W-1:0] WEEKDAY_LIMIT = 3'd7;

  // one schedule entry as stored in the RAM
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MASK_W-1:0]   mask;
    logic [COUNT_W-1:0]  stored;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic rd_scan;
    logic wr_en;
    logic idx_clr;
    logic idx_inc;
    logic found;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_write;
    logic is_scan;
    logic hit;
    logic idx_last;
  } dp_status_t;

endpackage

// File: design/wsat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/wsat_ctrl.sv
// Controller state machine: sequences entry updates and tick scans.
// Depends on wsat_pkg for the state, command and status types.
`timescale 1ns / 1ps

module wsat_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wsat_pkg::dp_status_t st,
  output wsat_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  wsat_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      wsat_pkg::S_IDLE: begin
        if (start) begin
          if (st.is_write) begin
            state_next = wsat_pkg::S_RMW_RD;
          end else if (st.is_scan) begin
            state_next = wsat_pkg::S_SCAN_RD;
          end
        end
      end
      wsat_pkg::S_RMW_RD:  state_next = wsat_pkg::S_RMW_WR;
      wsat_pkg::S_RMW_WR:  state_next = wsat_pkg::S_IDLE;
      wsat_pkg::S_SCAN_RD: state_next = wsat_pkg::S_SCAN_CMP;
      wsat_pkg::S_SCAN_CMP: begin
        if (st.hit || st.idx_last) begin
          state_next = wsat_pkg::S_IDLE;
        end else begin
          state_next = wsat_pkg::S_SCAN_RD;
        end
      end
      default: state_next = wsat_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      wsat_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.accept  = start;
        cmd.idx_clr = start;
      end
      wsat_pkg::S_RMW_RD: begin
        cmd.rd_en = 1'b1;
      end
      wsat_pkg::S_RMW_WR: begin
        cmd.wr_en = 1'b1;
      end
      wsat_pkg::S_SCAN_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_scan = 1'b1;
      end
      wsat_pkg::S_SCAN_CMP: begin
        cmd.found   = st.hit;
        cmd.idx_inc = !st.hit && !st.idx_last;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef SYNTH
  // a request that needs no table access leaves the block idle
  a_quick_request: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !st.is_write && !st.is_scan) |=> !busy)
    else $error("request without table access left the block busy");

  // a table write lasts one cycle and follows its read
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> ($past(cmd.rd_en) && !$past(cmd.rd_scan)))
    else $error("entry write not preceded by its read");

  // a match is reported only on data read by the scan the cycle before
  a_found_after_scan_read: assert property (@(posedge clk) disable iff (rst)
    cmd.found |-> ($past(cmd.rd_en) && $past(cmd.rd_scan)))
    else $error("match reported without a scan read");

  // the block never accepts while a scan or update is under way
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != wsat_pkg::S_IDLE) |-> !cmd.accept)
    else $error("request accepted while busy");
`endif

endmodule

// File: design/wsat_dp.sv
// Datapath: request registers, entry RAM with valid bits, scan index,
// entry merge and match logic, result register. Depends on wsat_pkg, wsat_ram.
`timescale 1ns / 1ps

module wsat_dp #(
  parameter int NUM_ENTRIES = wsat_pkg::DEF_NUM_ENTRIES,
  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wsat_pkg::ctrl_cmd_t                 cmd,
  output wsat_pkg::dp_status_t                st,
  input  logic [wsat_pkg::CMD_W-1:0]          cmd_in,
  input  logic [wsat_pkg::ROW_W-1:0]          row,
  input  logic [wsat_pkg::HOUR_W-1:0]         hour,
  input  logic [wsat_pkg::MINUTE_W-1:0]       minute,
  input  logic [wsat_pkg::WDAY_W-1:0]         weekday,
  input  logic [wsat_pkg::COUNT_W-1:0]        count,
  output logic [wsat_pkg::COUNT_W-1:0]        portions,
  output logic                                strobe
);

  logic [wsat_pkg::CMD_W-1:0]    cmd_q;
  logic [IDX_W-1:0]              row_q;
  logic [wsat_pkg::HOUR_W-1:0]   hour_q;
  logic [wsat_pkg::MINUTE_W-1:0] minute_q;
  logic [wsat_pkg::WDAY_W-1:0]   weekday_q;
  logic [wsat_pkg::COUNT_W-1:0]  count_q;
  logic [wsat_pkg::MINUTE_W-1:0] last_minute;
  logic [NUM_ENTRIES-1:0]        valid;
  logic                          valid_q;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              raddr;
  logic [wsat_pkg::ENTRY_W-1:0]  ram_q;
  wsat_pkg::entry_t              rd_entry;
  wsat_pkg::entry_t              wr_entry;
  logic                          row_ok;
  logic                          wday_ok;
  logic [wsat_pkg::COUNT_W-1:0]  dispense;

  // decode the request on the ports, flag the last entry and match the tick
  always_comb begin
    row_ok  = 32'(row) < 32'(NUM_ENTRIES);
    wday_ok = weekday < wsat_pkg::WEEKDAY_LIMIT;
    st.is_write = row_ok && ((cmd_in == wsat_pkg::CMD_SET_TIME) ||
                             (cmd_in == wsat_pkg::CMD_SET_PORTIONS) ||
                             ((cmd_in == wsat_pkg::CMD_SET_WEEKDAY) && wday_ok));
    st.is_scan  = (cmd_in == wsat_pkg::CMD_TICK) && (minute != last_minute) && wday_ok;
    st.idx_last = (idx == IDX_W'(NUM_ENTRIES - 1));
    st.hit      = (rd_entry.hour == hour_q) && (rd_entry.minute == minute_q) &&
                  rd_entry.mask[weekday_q];
  end

  // hold the request operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_q     <= cmd_in;
      row_q     <= IDX_W'(row);
      hour_q    <= hour;
      minute_q  <= minute;
      weekday_q <= weekday;
      count_q   <= count;
    end
  end

  // track the minute of the previous tick
  always_ff @(posedge clk) begin
    if (rst) begin
      last_minute <= '0;
    end else if (cmd.accept && (cmd_in == wsat_pkg::CMD_TICK)) begin
      last_minute <= minute;
    end
  end

  // valid bits: drop all on clear, mark an entry on write
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.accept && (cmd_in == wsat_pkg::CMD_CLEAR)) begin
      valid <= '0;
    end else if (cmd.wr_en) begin
      valid[row_q] <= 1'b1;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  assign raddr = cmd.rd_scan ? idx : row_q;

  // valid bit follows the registered read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      valid_q <= valid[raddr];
    end
  end

  wsat_ram #(
    .WIDTH(wsat_pkg::ENTRY_W),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(row_q),
    .wdata(wr_entry),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // an entry never written since the last clear reads as zero
  assign rd_entry = valid_q ? wsat_pkg::entry_t'(ram_q) : '0;

  // merge the update into the entry
  always_comb begin
    wr_entry = rd_entry;
    case (cmd_q)
      wsat_pkg::CMD_SET_TIME: begin
        wr_entry.hour   = hour_q;
        wr_entry.minute = minute_q;
      end
      wsat_pkg::CMD_SET_PORTIONS: begin
        wr_entry.stored = count_q - wsat_pkg::COUNT_W'(1);
      end
      wsat_pkg::CMD_SET_WEEKDAY: begin
        wr_entry.mask = rd_entry.mask | (wsat_pkg::MASK_W'(1) << weekday_q);
      end
      default: begin
        wr_entry = rd_entry;
      end
    endcase
  end

  // portions owed by the entry read
  assign dispense = rd_entry.stored + wsat_pkg::COUNT_W'(1);

  // result register: a zero count gives no result
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.found && (dispense != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.found) begin
      portions <= dispense;
    end
  end

endmodule

// File: design/weekly_schedule_alarm_table_top.sv
// Top level of the weekly schedule alarm table: controller plus datapath.
// Depends on wsat_pkg, wsat_ctrl, wsat_dp (and through it wsat_ram).
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. Clear-all,
// ticks that are not acted on and unused commands need no table access. Set
// time, set portions and set weekday bit go through a read and a write state:
// the entry is read from the single-port-read entry RAM, merged and written
// back. An acted-on tick scans the entries in order, each with a RAM read
// state and then a compare state, and stops at the first matching entry or
// after the last entry. A dispense result appears on portions with strobe
// high for exactly one cycle, the cycle after the matching compare; the
// receiver cannot stall it, and a new request may be accepted in that same
// cycle. No clearing pass is needed after reset: per-entry valid bits make
// the table read as zero at once.
module weekly_schedule_alarm_table_top #(
  parameter int NUM_ENTRIES = wsat_pkg::DEF_NUM_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [wsat_pkg::CMD_W-1:0]    cmd,
  input  logic [wsat_pkg::ROW_W-1:0]    row,
  input  logic [wsat_pkg::HOUR_W-1:0]   hour,
  input  logic [wsat_pkg::MINUTE_W-1:0] minute,
  input  logic [wsat_pkg::WDAY_W-1:0]   weekday,
  input  logic [wsat_pkg::COUNT_W-1:0]  count,
  output logic [wsat_pkg::COUNT_W-1:0]  portions,
  output logic                          strobe
);

  wsat_pkg::ctrl_cmd_t  ctrl_cmd;
  wsat_pkg::dp_status_t dp_st;

  // sequencer
  wsat_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (dp_st),
    .cmd  (ctrl_cmd),
    .busy (busy)
  );

  // table storage and match logic
  wsat_dp #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ctrl_cmd),
    .st      (dp_st),
    .cmd_in  (cmd),
    .row     (row),
    .hour    (hour),
    .minute  (minute),
    .weekday (weekday),
    .count   (count),
    .portions(portions),
    .strobe  (strobe)
  );

endmodule

// File: tb/tb_weekly_schedule_alarm_table_top.sv
// Self-checking testbench for weekly_schedule_alarm_table_top: directed and random requests.
// Depends on wsat_pkg and the design files; a scoreboard class predicts every dispense.
`timescale 1ns / 1ps

module tb_weekly_schedule_alarm_table_top;
  import wsat_pkg::*;

  localparam int NUM_ENTRIES  = DEF_NUM_ENTRIES;
  // longest request is an acted-on tick that scans every entry
  localparam int SCAN_CYCLES  = 2 * NUM_ENTRIES + 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1000;

  // command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  // predicts dispense results and checks them in order
  class dispense_scoreboard;
    entry_t              sched [NUM_ENTRIES];
    logic [MINUTE_W-1:0] prev_minute;
    logic [COUNT_W-1:0]  expected_portions [$];
    int                  errors;

    function new();
      foreach (sched[i]) sched[i] = '0;
      prev_minute = '0;
      errors      = 0;
    endfunction

    function void report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endfunction

    function int pending();
      return expected_portions.size();
    endfunction

    // first matching entry decides; a stored 255 stops the scan with no result
    function void scan_entries(logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m,
                               logic [WDAY_W-1:0] w);
      logic [COUNT_W-1:0] amount;
      bit                 hit;
      hit = 0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (!hit && sched[i].hour == h && sched[i].minute == m && sched[i].mask[w]) begin
          hit    = 1;
          amount = sched[i].stored + 8'd1;
          if (amount != '0) expected_portions.push_back(amount);
        end
      end
    endfunction

    // apply one accepted request to the shadow table
    function void note_request(logic [CMD_W-1:0] c, logic [ROW_W-1:0] r,
                               logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m,
                               logic [WDAY_W-1:0] w, logic [COUNT_W-1:0] n);
      bit row_ok;
      row_ok = int'(r) < NUM_ENTRIES;
      case (c)
        CMD_CLEAR: begin
          foreach (sched[i]) sched[i] = '0;
        end
        CMD_SET_TIME: begin
          if (row_ok) begin
            sched[r].hour   = h;
            sched[r].minute = m;
          end
        end
        CMD_SET_PORTIONS: begin
          if (row_ok) sched[r].stored = n - 8'd1;
        end
        CMD_SET_WEEKDAY: begin
          if (row_ok && w < WEEKDAY_LIMIT) sched[r].mask[w] = 1'b1;
        end
        CMD_TICK: begin
          if (m != prev_minute && w < WEEKDAY_LIMIT) scan_entries(h, m, w);
          prev_minute = m;
        end
        default: ;
      endcase
    endfunction

    function void check_dispense(logic [COUNT_W-1:0] got);
      logic [COUNT_W-1:0] want;
      if (expected_portions.size() == 0) begin
        report($sformatf("unexpected dispense of %0d portions", got));
      end else begin
        want = expected_portions.pop_front();
        if (got !== want)
          report($sformatf("portions %0d, expected %0d", got, want));
      end
    endfunction
  endclass

  logic                clk     = 1'b0;
  logic                rst     = 1'b1;
  logic                start   = 1'b0;
  logic [CMD_W-1:0]    cmd     = '0;
  logic [ROW_W-1:0]    row     = '0;
  logic [HOUR_W-1:0]   hour    = '0;
  logic [MINUTE_W-1:0] minute  = '0;
  logic [WDAY_W-1:0]   weekday = '0;
  logic [COUNT_W-1:0]  count   = '0;
  logic                busy;
  logic [COUNT_W-1:0]  portions;
  logic                strobe;

  dispense_scoreboard  sb = new();
  int                  cycles = 0;
  int                  burst_left = 1;
  int                  items = 0;
  logic [MINUTE_W-1:0] last_tick_min = '0;

  weekly_schedule_alarm_table_top #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .row     (row),
    .hour    (hour),
    .minute  (minute),
    .weekday (weekday),
    .count   (count),
    .portions(portions),
    .strobe  (strobe)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // check results first, then note the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sb.check_dispense(portions);
      if (start && !busy) sb.note_request(cmd, row, hour, minute, weekday, count);
    end
  end

  // hold one request until the block takes it
  task automatic issue(logic [CMD_W-1:0] c, logic [ROW_W-1:0] r, logic [HOUR_W-1:0] h,
                       logic [MINUTE_W-1:0] m, logic [WDAY_W-1:0] w,
                       logic [COUNT_W-1:0] n);
    start   <= 1'b1;
    cmd     <= c;
    row     <= r;
    hour    <= h;
    minute  <= m;
    weekday <= w;
    count   <= n;
    do @(posedge clk); while (busy);
    if (c == CMD_TICK) last_tick_min = m;
    items++;
    // end the burst with an idle gap of random length, which may be zero
    burst_left--;
    if (burst_left <= 0) begin
      int gap;
      gap        = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 20);
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        start   <= 1'b0;
        cmd     <= CMD_TICK;
        row     <= $urandom;
        hour    <= $urandom;
        minute  <= $urandom;
        weekday <= $urandom;
        count   <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop start and wait until every dispense has come and the scan has ended
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  // one random request, mostly shaped to hit the table
  task automatic random_request();
    int                  sel;
    int                  r;
    entry_t              e;
    logic [WDAY_W-1:0]   w;
    logic [HOUR_W-1:0]   h;
    logic [MINUTE_W-1:0] m;
    sel = $urandom_range(99);
    r   = $urandom_range(NUM_ENTRIES - 1);
    h   = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
    m   = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
    if (sel < 2) begin
      issue(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 16) begin
      issue(CMD_SET_TIME, r, h, m, $urandom, $urandom);
    end else if (sel < 30) begin
      issue(CMD_SET_PORTIONS, r, $urandom, $urandom, $urandom, $urandom_range(255));
    end else if (sel < 46) begin
      issue(CMD_SET_WEEKDAY, r, $urandom, $urandom, $urandom_range(7), $urandom);
    end else if (sel < 50) begin
      issue($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (sel < 65) begin
      issue(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      // aim a tick at a stored entry, first moving the minute if needed
      e = sb.sched[r];
      w = $urandom_range(7);
      if (e.mask != '0 && $urandom_range(3) != 0) begin
        do w = $urandom_range(6); while (!e.mask[w]);
      end
      if (e.minute == last_tick_min)
        issue(CMD_TICK, $urandom, $urandom, e.minute ^ 6'd1, $urandom, $urandom);
      issue(CMD_TICK, $urandom, e.hour, e.minute, w, $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first tick at minute 0 is not acted on; the repeat after a move is
    issue(CMD_SET_TIME, 0, 0, 0, 0, 0);
    issue(CMD_SET_WEEKDAY, 0, 0, 0, 0, 0);
    issue(CMD_SET_PORTIONS, 0, 0, 0, 0, 5);
    issue(CMD_TICK, 0, 0, 0, 0, 0);
    issue(CMD_TICK, 0, 0, 1, 0, 0);
    issue(CMD_TICK, 0, 0, 0, 0, 0);
    // zero portions in the first match stops the scan
    issue(CMD_SET_TIME, 1, 23, 59, 0, 0);
    issue(CMD_SET_WEEKDAY, 1, 0, 0, 6, 0);
    issue(CMD_SET_PORTIONS, 1, 0, 0, 0, 0);
    issue(CMD_SET_TIME, 2, 23, 59, 0, 0);
    issue(CMD_SET_WEEKDAY, 2, 0, 0, 6, 0);
    issue(CMD_SET_PORTIONS, 2, 0, 0, 0, 255);
    issue(CMD_TICK, 7, 23, 59, 6, 8'hff);
    // move the blocking entry away so the second one gives 255
    issue(CMD_SET_TIME, 1, 12, 30, 0, 0);
    issue(CMD_TICK, 0, 23, 58, 6, 0);
    issue(CMD_TICK, 0, 23, 59, 6, 0);
    // weekday beyond Saturday and out-of-range time
    issue(CMD_SET_WEEKDAY, 3, 0, 0, 7, 0);
    issue(CMD_SET_TIME, 3, 31, 63, 0, 0);
    issue(CMD_SET_WEEKDAY, 3, 0, 0, 2, 0);
    issue(CMD_SET_PORTIONS, 3, 0, 0, 0, 1);
    issue(CMD_TICK, 0, 31, 63, 7, 0);
    issue(CMD_TICK, 0, 31, 62, 2, 0);
    issue(CMD_TICK, 0, 31, 63, 2, 0);
    // unused commands, then clear all keeps the last minute
    issue(CMD_SPARE_A, 7, 31, 63, 7, 8'hff);
    issue(CMD_SPARE_B, 7, 31, 63, 7, 8'hff);
    issue(CMD_SPARE_C, 7, 31, 63, 7, 8'hff);
    issue(CMD_CLEAR, 7, 31, 63, 7, 8'hff);
    issue(CMD_TICK, 0, 0, 0, 0, 0);
    drain();

    // random part, pausing fully once or twice midway
    items = 0;
    while (items < RANDOM_ITEMS) begin
      random_request();
      if (items >= RANDOM_ITEMS / 2 && items < RANDOM_ITEMS / 2 + 2) drain();
    end
    drain();

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/wsat_pkg.sv
design/wsat_ram.sv
design/wsat_ctrl.sv
design/wsat_dp.sv
design/weekly_schedule_alarm_table_top.sv
tb/tb_weekly_schedule_alarm_table_top.sv
